[hw/rtl/lsms_pkg.sv]
// Shared types and constants for the LED strip mode sequencer.
// Holds mode, action, button and strip operation codes, reset values and the preset table.
// No dependencies.
`default_nettype none
package lsms_pkg;

  localparam int unsigned STRIP_LEN_INT = 190;
  localparam logic [7:0] STRIP_LENGTH = 8'(STRIP_LEN_INT);
  localparam logic [7:0] STRIP_HALF = 8'(STRIP_LEN_INT / 2);

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_START    = 3'd1,
    MODE_COLOR    = 3'd2,
    MODE_BLACKOUT = 3'd3,
    MODE_NIGHT    = 3'd4,
    MODE_SUNRISE  = 3'd5,
    MODE_SUNSET   = 3'd6,
    MODE_MULTI    = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_FILL  = 3'd1,
    OP_CLEAR = 3'd2,
    OP_NIGHT = 3'd3,
    OP_PAINT = 3'd4
  } op_t;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_BUTTON = 2'd1;
  localparam logic [1:0] ACT_MODE   = 2'd2;

  localparam logic [4:0] BTN_BRIGHT_UP = 5'd0;
  localparam logic [4:0] BTN_BRIGHT_DN = 5'd1;
  localparam logic [4:0] BTN_RED_UP    = 5'd2;
  localparam logic [4:0] BTN_RED_DN    = 5'd3;
  localparam logic [4:0] BTN_GREEN_UP  = 5'd4;
  localparam logic [4:0] BTN_GREEN_DN  = 5'd5;
  localparam logic [4:0] BTN_BLUE_UP   = 5'd6;
  localparam logic [4:0] BTN_BLUE_DN   = 5'd7;
  localparam logic [4:0] BTN_PRESET_LO = 5'd8;
  localparam logic [4:0] BTN_PRESET_HI = 5'd27;

  localparam logic [2:0] CFG_SUNRISE_STEP = 3'd0;
  localparam logic [2:0] CFG_FADE_STEP    = 3'd1;
  localparam logic [2:0] CFG_NIGHT_STEP   = 3'd2;
  localparam logic [2:0] CFG_WIPE_STEP    = 3'd3;
  localparam logic [2:0] CFG_START_DELAY  = 3'd4;

  localparam logic [15:0] RST_SUNRISE_STEP = 16'd9375;
  localparam logic [15:0] RST_FADE_STEP    = 16'd300;
  localparam logic [15:0] RST_NIGHT_STEP   = 16'd200;
  localparam logic [15:0] RST_WIPE_STEP    = 16'd300;
  localparam logic [15:0] RST_START_DELAY  = 16'd1000;

  localparam logic [7:0] RST_LEVEL = 8'd10;
  localparam logic [7:0] RST_RED   = 8'd30;
  localparam logic [7:0] RST_GREEN = 8'd180;
  localparam logic [7:0] RST_BLUE  = 8'd255;

  localparam logic [7:0]  LEVEL_MAX       = 8'd255;
  localparam logic [7:0]  LEVEL_STEP      = 8'd10;
  localparam logic [7:0]  LEVEL_UP_LIMIT  = 8'd245;
  localparam logic [7:0]  LEVEL_FLOOR     = 8'd5;
  localparam logic [7:0]  NIGHT_LEVEL_TOP = 8'd50;
  localparam logic [15:0] DELAY_MAX       = 16'hFFFF;

  localparam logic [23:0] SUNSET_RGB = {8'd10, 8'd200, 8'd200};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic rgb_t preset_rgb(input logic [4:0] btn);
    rgb_t c;
    case (btn)
      5'd8:  c = '{8'd255, 8'd0,   8'd0};
      5'd9:  c = '{8'd255, 8'd10,  8'd0};
      5'd10: c = '{8'd245, 8'd25,  8'd0};
      5'd11: c = '{8'd240, 8'd39,  8'd2};
      5'd12: c = '{8'd255, 8'd255, 8'd0};
      5'd13: c = '{8'd0,   8'd100, 8'd0};
      5'd14: c = '{8'd24,  8'd105, 8'd15};
      5'd15: c = '{8'd255, 8'd255, 8'd15};
      5'd16: c = '{8'd34,  8'd98,  8'd225};
      5'd17: c = '{8'd40,  8'd110, 8'd200};
      5'd18: c = '{8'd0,   8'd0,   8'd128};
      5'd19: c = '{8'd12,  8'd120, 8'd255};
      5'd20: c = '{8'd255, 8'd0,   8'd10};
      5'd21: c = '{8'd70,  8'd24,  8'd122};
      5'd22: c = '{8'd255, 8'd100, 8'd255};
      5'd23: c = '{8'd255, 8'd255, 8'd255};
      5'd24: c = '{8'd216, 8'd30,  8'd24};
      5'd25: c = '{8'd174, 8'd38,  8'd32};
      5'd26: c = '{8'd40,  8'd103, 8'd39};
      5'd27: c = '{8'd45,  8'd110, 8'd89};
      default: c = '{8'd0, 8'd0, 8'd0};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/led_strip_mode_sequencer_core.sv]
// LED strip mode sequencer: mode, brightness, color, wipe and timer state with one result per word.
// Depends on lsms_pkg for codes, reset values and the preset color table.
//
// Usage:
//   Input channel (in_valid / in_stall / in_action, in_button, in_mode_request) carries
//   one word per 1 ms tick, remote button or mode command. Every accepted word yields
//   exactly one result word on the output channel (out_valid / out_stall / out_* fields):
//   the mode and brightness after the word and at most one strip operation.
//   Latency: the result is valid in the cycle after the input word is accepted.
//   Throughput: one word per cycle unless stalled; state is updated at the accepting edge,
//   so the next word sees it at once. The result register is the only buffer between the sides.
//   Stall: while a result waits under out_stall, in_stall is raised and no word is taken;
//   when the result is taken in a cycle, a new word can be accepted in the same cycle.
//   Configuration: cfg_wr_en writes cfg_wdata into the step/delay register cfg_index
//   at the clock edge; writes are expected only while the block is idle.
//   Reset (rst_n low, synchronous): mode OFF, brightness 10, color 30/180/255, pending
//   action and start arm set, wipe indices at half the strip, counters zero, no result.
`default_nettype none
module led_strip_mode_sequencer_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [15:0]          cfg_wdata,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [1:0]           in_action,
  input  wire logic [4:0]           in_button,
  input  wire logic [2:0]           in_mode_request,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [2:0]           out_mode_now,
  output      logic [7:0]           out_brightness_now,
  output      logic [2:0]           out_strip_op,
  output      logic [7:0]           out_left_index,
  output      logic [7:0]           out_right_index,
  output      logic [7:0]           out_op_red,
  output      logic [7:0]           out_op_green,
  output      logic [7:0]           out_op_blue
);
  import lsms_pkg::*;

  logic [15:0] sunrise_step_r, fade_step_r, night_step_r, wipe_step_r, start_delay_r;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  level_r, level_nxt;
  rgb_t        color_r, color_nxt;
  logic        pending_r, pending_nxt;
  logic        armed_r, armed_nxt;
  logic [7:0]  wipe_left_r, wipe_left_nxt;
  logic [7:0]  wipe_right_r, wipe_right_nxt;
  logic [15:0] period_r, period_nxt;
  logic [15:0] delay_r, delay_nxt;

  logic        out_valid_r;
  op_t         op_r, op_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  right_r, right_nxt;
  rgb_t        op_color_r, op_color_nxt;
  mode_t       mode_out_r;
  logic [7:0]  level_out_r;

  logic        accept;
  logic        is_tick;
  logic [15:0] step_sel;
  logic [16:0] cnt_inc;
  logic        fire;
  logic [15:0] period_upd;
  logic [15:0] delay_eff;
  logic        wipe_run;
  logic        wipe_paint;
  logic [7:0]  right_inc;
  logic [7:0]  level_up, level_dn;
  rgb_t        preset;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign is_tick  = (in_action == ACT_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sunrise_step_r <= RST_SUNRISE_STEP;
      fade_step_r    <= RST_FADE_STEP;
      night_step_r   <= RST_NIGHT_STEP;
      wipe_step_r    <= RST_WIPE_STEP;
      start_delay_r  <= RST_START_DELAY;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SUNRISE_STEP: sunrise_step_r <= cfg_wdata;
        CFG_FADE_STEP:    fade_step_r    <= cfg_wdata;
        CFG_NIGHT_STEP:   night_step_r   <= cfg_wdata;
        CFG_WIPE_STEP:    wipe_step_r    <= cfg_wdata;
        CFG_START_DELAY:  start_delay_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mode_r)
      MODE_SUNRISE:  step_sel = sunrise_step_r;
      MODE_BLACKOUT: step_sel = fade_step_r;
      MODE_NIGHT:    step_sel = night_step_r;
      default:       step_sel = wipe_step_r;
    endcase
  end

  assign cnt_inc    = {1'b0, period_r} + 17'd1;
  assign fire       = (cnt_inc >= {1'b0, step_sel});
  assign period_upd = fire ? 16'd0 : cnt_inc[15:0];
  assign delay_eff  = (mode_r == MODE_START && armed_r) ? 16'd0 : delay_r;
  assign wipe_run   = (mode_r == MODE_SUNSET) ||
                      (mode_r == MODE_START && delay_eff >= start_delay_r);
  assign wipe_paint = wipe_run && fire && (wipe_right_r < STRIP_LENGTH);
  assign right_inc  = wipe_paint ? wipe_right_r + 8'd1 : wipe_right_r;
  assign preset     = preset_rgb(in_button);

  always_comb begin
    logic [7:0] l0;
    l0       = (level_r == 8'd0) ? LEVEL_FLOOR : level_r;
    level_up = (l0 <= LEVEL_UP_LIMIT) ? l0 + LEVEL_STEP : l0;
    l0       = (level_r >= LEVEL_STEP) ? level_r - LEVEL_STEP : level_r;
    level_dn = (l0 == LEVEL_FLOOR) ? 8'd0 : l0;
  end

  // next state
  always_comb begin
    mode_nxt       = mode_r;
    level_nxt      = level_r;
    color_nxt      = color_r;
    pending_nxt    = pending_r;
    armed_nxt      = armed_r;
    wipe_left_nxt  = wipe_left_r;
    wipe_right_nxt = wipe_right_r;
    period_nxt     = period_r;
    delay_nxt      = delay_r;
    if (accept) begin
      case (in_action)
        ACT_TICK: begin
          case (mode_r)
            MODE_START, MODE_SUNSET: begin
              if (mode_r == MODE_START) begin
                armed_nxt = 1'b0;
              end
              if (wipe_run) begin
                period_nxt = period_upd;
                if (right_inc == STRIP_LENGTH) begin
                  mode_nxt       = (mode_r == MODE_START) ? MODE_COLOR : MODE_BLACKOUT;
                  period_nxt     = 16'd0;
                  wipe_left_nxt  = STRIP_HALF;
                  wipe_right_nxt = STRIP_HALF;
                end else if (wipe_paint) begin
                  wipe_right_nxt = right_inc;
                  wipe_left_nxt  = wipe_left_r - 8'd1;
                end
              end
            end
            MODE_SUNRISE: begin
              if (level_r < LEVEL_MAX) begin
                period_nxt = period_upd;
                if (fire) begin
                  level_nxt = level_r + 8'd1;
                end
              end
            end
            MODE_BLACKOUT: begin
              period_nxt = period_upd;
              if (fire) begin
                if (level_r > 8'd1) begin
                  level_nxt = level_r - 8'd1;
                end else begin
                  level_nxt  = 8'd0;
                  mode_nxt   = MODE_OFF;
                  period_nxt = 16'd0;
                end
              end
            end
            MODE_NIGHT: begin
              period_nxt = period_upd;
              if (fire && level_r < NIGHT_LEVEL_TOP) begin
                level_nxt = level_r + 8'd1;
              end
            end
            MODE_OFF: begin
              if (pending_r) begin
                armed_nxt = 1'b1;
              end
            end
            default: ;
          endcase
          pending_nxt = 1'b0;
          delay_nxt   = (delay_eff < DELAY_MAX) ? delay_eff + 16'd1 : delay_eff;
        end
        ACT_BUTTON: begin
          case (in_button)
            BTN_BRIGHT_UP: level_nxt       = level_up;
            BTN_BRIGHT_DN: level_nxt       = level_dn;
            BTN_RED_UP:    color_nxt.red   = color_r.red + 8'd1;
            BTN_RED_DN:    color_nxt.red   = color_r.red - 8'd1;
            BTN_GREEN_UP:  color_nxt.green = color_r.green + 8'd1;
            BTN_GREEN_DN:  color_nxt.green = color_r.green - 8'd1;
            BTN_BLUE_UP:   color_nxt.blue  = color_r.blue + 8'd1;
            BTN_BLUE_DN:   color_nxt.blue  = color_r.blue - 8'd1;
            default: begin
              if (in_button >= BTN_PRESET_LO && in_button <= BTN_PRESET_HI) begin
                pending_nxt = 1'b1;
                mode_nxt    = MODE_COLOR;
                period_nxt  = 16'd0;
                color_nxt   = preset;
              end
            end
          endcase
        end
        ACT_MODE: begin
          pending_nxt = 1'b1;
          mode_nxt    = mode_t'(in_mode_request);
          period_nxt  = 16'd0;
        end
        default: ;
      endcase
    end
  end

  // result word
  always_comb begin
    op_nxt       = OP_NONE;
    left_nxt     = 8'd0;
    right_nxt    = 8'd0;
    op_color_nxt = '{8'd0, 8'd0, 8'd0};
    if (is_tick) begin
      case (mode_r)
        MODE_COLOR: begin
          if (pending_r) begin
            op_nxt       = OP_FILL;
            op_color_nxt = color_r;
          end
        end
        MODE_OFF: begin
          if (pending_r) begin
            op_nxt = OP_CLEAR;
          end
        end
        MODE_NIGHT: begin
          if (fire && level_r < NIGHT_LEVEL_TOP) begin
            op_nxt = OP_NIGHT;
          end
        end
        MODE_START, MODE_SUNSET: begin
          if (wipe_paint) begin
            op_nxt       = OP_PAINT;
            left_nxt     = wipe_left_r;
            right_nxt    = wipe_right_r;
            op_color_nxt = (mode_r == MODE_START) ? color_r : rgb_t'(SUNSET_RGB);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_OFF;
      level_r      <= RST_LEVEL;
      color_r      <= '{RST_RED, RST_GREEN, RST_BLUE};
      pending_r    <= 1'b1;
      armed_r      <= 1'b1;
      wipe_left_r  <= STRIP_HALF;
      wipe_right_r <= STRIP_HALF;
      period_r     <= 16'd0;
      delay_r      <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      level_r      <= level_nxt;
      color_r      <= color_nxt;
      pending_r    <= pending_nxt;
      armed_r      <= armed_nxt;
      wipe_left_r  <= wipe_left_nxt;
      wipe_right_r <= wipe_right_nxt;
      period_r     <= period_nxt;
      delay_r      <= delay_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= op_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      op_color_r  <= op_color_nxt;
      mode_out_r  <= mode_nxt;
      level_out_r <= level_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode_now       = mode_out_r;
  assign out_brightness_now = level_out_r;
  assign out_strip_op       = op_r;
  assign out_left_index     = left_r;
  assign out_right_index    = right_r;
  assign out_op_red         = op_color_r.red;
  assign out_op_green       = op_color_r.green;
  assign out_op_blue        = op_color_r.blue;

endmodule
`default_nettype wire
